/* src/nti_pkg.sv */
// Shared types, constants and saturating helpers for the table interpolator.
package nti_pkg;

  localparam int DATA_W     = 64;
  localparam int IDX_W      = 11;
  localparam int INDEX_CAP  = 330;
  localparam int MAX_PROBES = 50;
  localparam int FRAC_BITS  = 24;
  localparam int NUM_SEG    = 12;

  localparam logic [8:0]  OFFSET_RESET = 9'd310;
  localparam logic [63:0] SAT_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN      = 64'h8000_0000_0000_0000;

  // Temperature segments: upper bound and start in degrees, step in tenths,
  // index of the segment start.
  localparam int SEG_BOUND  [NUM_SEG] = '{250, 350, 360, 370, 372, 378,
                                          380, 390, 400, 450, 550, 1000};
  localparam int SEG_LO     [NUM_SEG] = '{0, 250, 350, 360, 370, 372,
                                          378, 380, 390, 400, 450, 550};
  localparam int SEG_STEP10 [NUM_SEG] = '{50, 20, 10, 5, 2, 1,
                                          2, 5, 10, 20, 50, 100};
  localparam int SEG_BASE   [NUM_SEG] = '{0, 50, 100, 110, 130, 140,
                                          200, 210, 230, 240, 265, 285};

  typedef enum logic [1:0] {
    OP_LOAD, OP_FWD, OP_INV, OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    ST_OK, ST_RANGE, ST_NOCONV, ST_ZERODEN
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SEG_GO, S_SEG_STEP, S_FWD_CHK, S_SRCH_CHK, S_SRCH_CMP,
    S_HIT_CAP, S_FIN_CMP, S_FETCH, S_CALC, S_MUL, S_DIV_GO, S_DIV_WAIT
  } state_t;

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if ((a[63] ^ b[63]) && (a[63] ^ r[63])) sat_sub = a[63] ? SAT_MIN : SAT_MAX;
    else sat_sub = r;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (!(a[63] ^ b[63]) && (a[63] ^ r[63])) sat_add = a[63] ? SAT_MIN : SAT_MAX;
    else sat_add = r;
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] a);
    mag = a[63] ? (~a + 64'd1) : a;
  endfunction

endpackage

/* src/nonuniform_table_interpolator.sv */
// Top level: nonuniform property table interpolator with its sequencer.
// Pulse start while busy is low to issue one item; exactly one result follows
// on value/status, marked by a single-cycle done strobe that cannot be held
// off, so the receiver must take it in that cycle. A load answers in the cycle
// after it is taken and never raises busy. A forward lookup above 1000 degrees
// skips the segment index, and an inverse lookup runs its search probes first;
// early error exits are shorter. Both kinds end in the shared divider, which
// produces one quotient bit per cycle, after four 32x32 partial products
// for the 64x64 product; the segment index takes a six-step compare
// and subtract. The table has no reset; entries read before they are loaded
// give undefined results. index_offset may be written only while busy is low
// and no result is pending.
module nonuniform_table_interpolator #(
  parameter int TABLE_DEPTH   = 32,
  parameter int PROPERTY_ROWS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [2:0]         property_row,
  input  logic [4:0]         entry_index,
  input  logic signed [63:0] entry_value,
  input  logic [34:0]        temperature,
  input  logic signed [63:0] pressure,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_wdata,
  output logic               done,
  output logic signed [63:0] value,
  output logic [1:0]         status
);

  localparam int AW    = $clog2(TABLE_DEPTH * PROPERTY_ROWS);
  localparam int IDX_W = nti_pkg::IDX_W;
  localparam logic [AW-1:0] TD_A = AW'(TABLE_DEPTH);
  localparam logic signed [IDX_W-1:0] G_LAST = IDX_W'(TABLE_DEPTH - 1);

  nti_pkg::state_t state, state_next;

  logic [8:0]  offset;
  logic [2:0]  row_r;
  logic [34:0] t_r;
  logic [63:0] p_r;
  logic [3:0]  seg_k;
  logic [3:0]  seg_sel;
  logic        seg_hit;
  logic signed [IDX_W-1:0] g, imin, imax, imax_in, g_adj;
  logic [5:0]  probes;
  logic [2:0]  den_row, num_row;
  logic [63:0] x;
  logic [63:0] c0, c1, y0, y1;
  logic [2:0]  fcnt;
  logic [63:0] ma, mb, dv;
  logic        neg;
  logic [63:0] pp;
  logic [127:0] acc;
  logic [2:0]  mcnt, jm;
  logic [6:0]  shamt;

  logic        fin;
  nti_pkg::status_t fin_status;
  logic [63:0] fin_value;

  logic        mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] rdata;
  logic [2:0]  rd_row;
  logic signed [IDX_W-1:0] rd_col;

  logic        div_start, div_done;
  logic [127:0] div_q;
  logic [34:0] seg_diff;
  logic [38:0] seg_d10;
  logic [38:0] seg_rem, seg_dvs, seg_shf;
  logic [5:0]  seg_q, seg_q_next;
  logic [2:0]  seg_cnt;
  logic        seg_take;

  logic        load_ok, imax_bad, search_more, p_lt, p_eq;
  logic [63:0] lim, qm, qs;
  logic [63:0] n_w, d_w, dy_w;
  nti_pkg::op_t op_in;

  assign op_in = nti_pkg::op_t'(op);
  assign busy  = (state != nti_pkg::S_IDLE);

  // Segment select on the incoming temperature: lowest segment whose bound holds
  always_comb begin
    seg_sel = '0;
    seg_hit = 1'b0;
    for (int k = nti_pkg::NUM_SEG - 1; k >= 0; k--) begin
      if (temperature <= (35'(nti_pkg::SEG_BOUND[k]) << nti_pkg::FRAC_BITS)) begin
        seg_sel = 4'(k);
        seg_hit = 1'b1;
      end
    end
  end

  // Segment index: (t - lo) * 10 over step10 in Q.24, quotient below 64
  assign seg_diff   = t_r - (35'(nti_pkg::SEG_LO[seg_k]) << nti_pkg::FRAC_BITS);
  assign seg_d10    = (39'(seg_diff) << 3) + (39'(seg_diff) << 1);
  assign seg_dvs    = 39'(nti_pkg::SEG_STEP10[seg_k]) << nti_pkg::FRAC_BITS;
  assign seg_shf    = seg_dvs << seg_cnt;
  assign seg_take   = (seg_rem >= seg_shf);
  assign seg_q_next = seg_q | (6'(seg_take) << seg_cnt);

  // Misc decisions
  assign load_ok     = (32'(property_row) < PROPERTY_ROWS) && (32'(entry_index) < TABLE_DEPTH);
  assign imax_in     = IDX_W'(nti_pkg::INDEX_CAP) - IDX_W'(offset);
  assign imax_bad    = (imax_in < 0) || (imax_in > G_LAST);
  assign search_more = (imax - g) > IDX_W'(1);
  assign p_eq        = (p_r == rdata);
  assign p_lt        = $signed(p_r) < $signed(rdata);
  assign g_adj       = p_lt ? (g - IDX_W'(1)) : g;

  // Interpolation differences
  assign n_w  = nti_pkg::sat_sub(x, c0);
  assign d_w  = nti_pkg::sat_sub(c1, c0);
  assign dy_w = nti_pkg::sat_sub(y1, y0);

  // Quotient saturation and sign
  assign lim = neg ? nti_pkg::SAT_MIN : nti_pkg::SAT_MAX;
  assign qm  = ((div_q[127:64] != '0) || (div_q[63:0] > lim)) ? lim : div_q[63:0];
  assign qs  = neg ? (~qm + 64'd1) : qm;

  // Table write from load items
  assign mem_we = start && !busy && (op_in == nti_pkg::OP_LOAD) && load_ok;
  assign waddr  = AW'(property_row) * TD_A + AW'(entry_index);
  assign raddr  = AW'(rd_row) * TD_A + AW'(unsigned'(rd_col));

  // Partial product placement
  assign jm    = mcnt - 3'd1;
  assign shamt = 7'({1'b0, jm[1]} + {1'b0, jm[0]}) << 5;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= nti_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Next state, read address and result selection
  always_comb begin
    state_next = state;
    fin        = 1'b0;
    fin_status = nti_pkg::ST_OK;
    fin_value  = '0;
    div_start  = 1'b0;
    mem_re     = 1'b0;
    rd_row     = 3'd1;
    rd_col     = g;
    unique case (state)
      nti_pkg::S_IDLE: begin
        if (start) begin
          case (op_in)
            nti_pkg::OP_LOAD: begin
              fin        = 1'b1;
              fin_status = load_ok ? nti_pkg::ST_OK : nti_pkg::ST_RANGE;
            end
            nti_pkg::OP_FWD: begin
              state_next = seg_hit ? nti_pkg::S_SEG_GO : nti_pkg::S_FWD_CHK;
            end
            nti_pkg::OP_INV: begin
              if (imax_bad) begin
                fin        = 1'b1;
                fin_status = nti_pkg::ST_RANGE;
              end else begin
                state_next = nti_pkg::S_SRCH_CHK;
              end
            end
            default: begin
              fin        = 1'b1;
              fin_status = nti_pkg::ST_RANGE;
            end
          endcase
        end
      end
      nti_pkg::S_SEG_GO: begin
        state_next = nti_pkg::S_SEG_STEP;
      end
      nti_pkg::S_SEG_STEP: begin
        if (seg_cnt == 3'd0) state_next = nti_pkg::S_FWD_CHK;
      end
      nti_pkg::S_FWD_CHK: begin
        if ((32'(row_r) >= PROPERTY_ROWS) || (g < 0) || (g >= G_LAST)) begin
          fin        = 1'b1;
          fin_status = nti_pkg::ST_RANGE;
          state_next = nti_pkg::S_IDLE;
        end else begin
          state_next = nti_pkg::S_FETCH;
        end
      end
      nti_pkg::S_SRCH_CHK: begin
        mem_re     = 1'b1;
        state_next = search_more ? nti_pkg::S_SRCH_CMP : nti_pkg::S_FIN_CMP;
      end
      nti_pkg::S_SRCH_CMP: begin
        if (p_eq) begin
          mem_re     = 1'b1;
          rd_row     = 3'd0;
          state_next = nti_pkg::S_HIT_CAP;
        end else if (32'(probes) + 1 > nti_pkg::MAX_PROBES) begin
          fin        = 1'b1;
          fin_status = nti_pkg::ST_NOCONV;
          state_next = nti_pkg::S_IDLE;
        end else begin
          state_next = nti_pkg::S_SRCH_CHK;
        end
      end
      nti_pkg::S_HIT_CAP: begin
        fin        = 1'b1;
        fin_value  = rdata;
        state_next = nti_pkg::S_IDLE;
      end
      nti_pkg::S_FIN_CMP: begin
        if ((g_adj < 0) || (g_adj >= G_LAST)) begin
          fin        = 1'b1;
          fin_status = nti_pkg::ST_RANGE;
          state_next = nti_pkg::S_IDLE;
        end else begin
          state_next = nti_pkg::S_FETCH;
        end
      end
      nti_pkg::S_FETCH: begin
        // Operand order: den(g), den(g+1), num(g), num(g+1)
        mem_re = (fcnt != 3'd4);
        rd_row = fcnt[1] ? num_row : den_row;
        rd_col = fcnt[0] ? (g + IDX_W'(1)) : g;
        if (fcnt == 3'd4) state_next = nti_pkg::S_CALC;
      end
      nti_pkg::S_CALC: begin
        if (c0 == c1) begin
          fin        = 1'b1;
          fin_status = nti_pkg::ST_ZERODEN;
          state_next = nti_pkg::S_IDLE;
        end else begin
          state_next = nti_pkg::S_MUL;
        end
      end
      nti_pkg::S_MUL: begin
        if (mcnt == 3'd4) state_next = nti_pkg::S_DIV_GO;
      end
      nti_pkg::S_DIV_GO: begin
        div_start  = 1'b1;
        state_next = nti_pkg::S_DIV_WAIT;
      end
      nti_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          fin        = 1'b1;
          fin_value  = nti_pkg::sat_add(y0, qs);
          state_next = nti_pkg::S_IDLE;
        end
      end
      default: state_next = nti_pkg::S_IDLE;
    endcase
  end

  // Control registers: result strobe and index offset
  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      offset <= nti_pkg::OFFSET_RESET;
    end else begin
      done <= fin;
      if (cfg_we) offset <= cfg_wdata;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (fin) begin
      value  <= fin_value;
      status <= fin_status;
    end
  end

  // Working registers of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      nti_pkg::S_IDLE: begin
        row_r  <= property_row;
        t_r    <= temperature;
        p_r    <= pressure;
        seg_k  <= seg_sel;
        imin   <= '0;
        imax   <= imax_in;
        probes <= '0;
        g      <= (op_in == nti_pkg::OP_FWD) ? imax_in : (imax_in >>> 1);
      end
      nti_pkg::S_SEG_GO: begin
        seg_rem <= seg_d10;
        seg_q   <= '0;
        seg_cnt <= 3'd5;
      end
      nti_pkg::S_SEG_STEP: begin
        // One quotient bit per cycle, most significant first
        if (seg_take) seg_rem <= seg_rem - seg_shf;
        seg_q   <= seg_q_next;
        seg_cnt <= seg_cnt - 3'd1;
        if (seg_cnt == 3'd0) begin
          g <= IDX_W'(nti_pkg::SEG_BASE[seg_k]) + IDX_W'(seg_q_next) - IDX_W'(offset);
        end
      end
      nti_pkg::S_FWD_CHK: begin
        den_row <= 3'd0;
        num_row <= row_r;
        x       <= 64'(t_r);
        fcnt    <= '0;
      end
      nti_pkg::S_SRCH_CMP: begin
        if (!p_eq) begin
          probes <= probes + 6'd1;
          if (p_lt) begin
            imax <= g;
            g    <= (g + imin) >>> 1;
          end else begin
            imin <= g;
            g    <= (imax + g) >>> 1;
          end
        end
      end
      nti_pkg::S_FIN_CMP: begin
        g       <= g_adj;
        den_row <= 3'd1;
        num_row <= 3'd0;
        x       <= p_r;
        fcnt    <= '0;
      end
      nti_pkg::S_FETCH: begin
        fcnt <= fcnt + 3'd1;
        case (fcnt)
          3'd1: c0 <= rdata;
          3'd2: c1 <= rdata;
          3'd3: y0 <= rdata;
          3'd4: y1 <= rdata;
          default: ;
        endcase
      end
      nti_pkg::S_CALC: begin
        neg  <= n_w[63] ^ d_w[63] ^ dy_w[63];
        ma   <= nti_pkg::mag(n_w);
        mb   <= nti_pkg::mag(dy_w);
        dv   <= nti_pkg::mag(d_w);
        acc  <= '0;
        mcnt <= '0;
      end
      nti_pkg::S_MUL: begin
        // Four 32x32 partial products, each registered before accumulation
        mcnt <= mcnt + 3'd1;
        if (mcnt != 3'd4) begin
          pp <= (mcnt[1] ? ma[63:32] : ma[31:0]) * (mcnt[0] ? mb[63:32] : mb[31:0]);
        end
        if (mcnt != 3'd0) acc <= acc + (128'(pp) << shamt);
      end
      default: ;
    endcase
  end

  nti_table #(
    .DEPTH (TABLE_DEPTH * PROPERTY_ROWS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (entry_value),
    .re    (mem_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  nti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (dv),
    .done     (div_done),
    .quotient (div_q)
  );

  // A result only follows a transfer or work in progress
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result without a pending item");

  // Errors always report a zero value
  assert property (@(posedge clk) disable iff (rst)
    (done && (status != nti_pkg::ST_OK)) |-> (value == '0))
    else $error("error result with nonzero value");

  // Leaving a lookup always delivers its result
  assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("lookup ended without a result");

endmodule

/* src/nti_table.sv */
// Property table storage: one write port, one registered read port.
module nti_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);

  logic [63:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

/* src/nti_div.sv */
// Restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit per cycle.
module nti_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] dividend,
  input  logic [63:0]  divisor,
  output logic         done,
  output logic [127:0] quotient
);

  logic [127:0] quo;
  logic [63:0]  rem;
  logic [63:0]  dv;
  logic [6:0]   cnt;
  logic         run;
  logic [64:0]  trial;

  // Trial subtract of the shifted remainder
  assign trial    = {rem, quo[127]} - {1'b0, dv};
  assign quotient = quo;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift-subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dv  <= divisor;
    end else if (run) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        quo <= {quo[126:0], 1'b1};
      end else begin
        rem <= {rem[62:0], quo[127]};
        quo <= {quo[126:0], 1'b0};
      end
    end
  end

endmodule
